// ===== rtl/versioned_key_slot_store_core_defines.svh =====
// assertion macros for the versioned key slot store
`ifndef VERSIONED_KEY_SLOT_STORE_CORE_DEFINES_SVH
`define VERSIONED_KEY_SLOT_STORE_CORE_DEFINES_SVH
`ifndef SYNTH
`define VKSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define VKSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define VKSS_ASSERT(lbl, prop, msg)
`define VKSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/vkss_pkg.sv =====
// types, codes and constants of the versioned key slot store
package vkss_pkg;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned KW_W       = 2;
  localparam int unsigned ADDR_W     = SLOT_W + KW_W;
  localparam int unsigned ENTRIES    = SLOT_COUNT * KEY_WORDS;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_USE    = 2'd2;

  localparam logic [1:0] KIND_AES  = 2'd0;
  localparam logic [1:0] KIND_P256 = 2'd1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_MISSING  = 2'd2;
  localparam logic [1:0] STAT_CONFLICT = 2'd3;

  // group order, most significant word first
  localparam word_t P256_ORDER [KEY_WORDS] = '{
    64'hFFFFFFFF00000000, 64'hFFFFFFFFFFFFFFFF,
    64'hBCE6FAADA7179E84, 64'hF3B9CAC2FC632551
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAL,
    S_EPQ,
    S_EPMAX,
    S_SCAN,
    S_COMMIT,
    S_USE,
    S_DONE
  } state_e;

endpackage

// ===== rtl/versioned_key_slot_store_core.sv =====
// versioned key slot store: sequencer around one shared 64-bit comparator
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | operation, slot, key_kind, key_word_0..3,
//          |           |                        | expected_epoch
//  out     | output    | out_valid_o/out_ready_i | status, epoch_out, key_out_0..3
//
// one item at a time, taken only in idle; scalar, epoch and duplicate checks share the
// comparator, one compare per cycle; the duplicate scan of an aes put reads the key memory
// one word a cycle
// reset clears all slots at once; key memory is never cleared, unloaded slots' words go unused
// the result waits in an output register; a stalled output holds the next result and the input

`include "versioned_key_slot_store_core_defines.svh"

module versioned_key_slot_store_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           slot_i,
  input  logic [1:0]           key_kind_i,
  input  vkss_pkg::word_t      key_word_0_i,
  input  vkss_pkg::word_t      key_word_1_i,
  input  vkss_pkg::word_t      key_word_2_i,
  input  vkss_pkg::word_t      key_word_3_i,
  input  vkss_pkg::word_t      expected_epoch_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output vkss_pkg::word_t      epoch_out_o,
  output vkss_pkg::word_t      key_out_0_o,
  output vkss_pkg::word_t      key_out_1_o,
  output vkss_pkg::word_t      key_out_2_o,
  output vkss_pkg::word_t      key_out_3_o
);
  import vkss_pkg::*;

  state_e state_q, state_d;

  // latched item
  logic [1:0]  op_q, kind_q;
  logic [7:0]  slot_q;
  word_t       key_q [KEY_WORDS];
  word_t       exp_q;

  // slot state
  word_t                 slot_epoch_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_kind_q, slot_loaded_q;

  // key memory
  word_t             key_mem [ENTRIES];
  word_t             rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;

  // sequencing
  logic [ADDR_W:0]   cnt_q, cnt_d;
  logic              p_vld_q, p_vld_d;
  logic [ADDR_W-1:0] p_idx_q, p_idx_d;
  logic              same_q, same_d;

  // result staging and output register
  logic [1:0] res_status_q, res_status_d;
  word_t      res_epoch_q, res_epoch_d;
  word_t      rel_q [KEY_WORDS];
  logic       rel_clr, rel_we;
  logic       out_valid_q, out_valid_d, out_ld;

  // slot update
  logic upd_en, upd_loaded, upd_kind;

  // shared comparator
  word_t cmp_a, cmp_b;
  logic  cmp_eq, cmp_lt;

  logic [SLOT_W-1:0] sidx, p_slot;
  logic [KW_W-1:0]   cw, p_word;
  word_t             cur_epoch, epoch_inc;
  logic              slot_ok, key_zero, same_cur;

  assign sidx      = slot_q[SLOT_W-1:0];
  assign cw        = cnt_q[KW_W-1:0];
  assign p_slot    = p_idx_q[ADDR_W-1:KW_W];
  assign p_word    = p_idx_q[KW_W-1:0];
  assign slot_ok   = ({1'b0, slot_q} < 9'(SLOT_COUNT));
  assign cur_epoch = slot_epoch_q[sidx];
  assign epoch_inc = cur_epoch + word_t'(1);
  assign key_zero  = ~|{key_q[0], key_q[1], key_q[2], key_q[3]};

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);
  assign same_cur = cmp_eq && ((p_word == '0) || same_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign mem_wa      = {sidx, cw};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    p_vld_d      = 1'b0;
    p_idx_d      = p_idx_q;
    same_d       = same_q;
    res_status_d = res_status_q;
    res_epoch_d  = res_epoch_q;
    rel_clr      = 1'b0;
    rel_we       = 1'b0;
    mem_we       = 1'b0;
    rd_addr      = mem_wa;
    upd_en       = 1'b0;
    upd_loaded   = 1'b0;
    upd_kind     = 1'b0;
    out_ld       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmp_a        = '0;
    cmp_b        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_d        = '0;
        rel_clr      = 1'b1;
        res_epoch_d  = '0;
        res_status_d = STAT_INVALID;
        state_d      = S_DONE;
        if (slot_ok) begin
          case (op_q)
            OP_PUT: begin
              if (kind_q == KIND_AES) begin
                state_d = S_EPQ;
              end else if (kind_q == KIND_P256 && !key_zero) begin
                state_d = S_SCAL;
              end
            end
            OP_REMOVE: begin
              state_d = S_EPQ;
            end
            OP_USE: begin
              res_epoch_d = cur_epoch;
              if (!slot_loaded_q[sidx]) begin
                res_status_d = STAT_MISSING;
              end else if (kind_q == {1'b0, slot_kind_q[sidx]}) begin
                state_d = S_USE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAL: begin
        // scalar against the group order, top word first
        cmp_a = key_q[cw];
        cmp_b = P256_ORDER[cw];
        if (cmp_lt) begin
          state_d = S_EPQ;
        end else if (!cmp_eq || cw == KW_W'(KEY_WORDS - 1)) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EPQ: begin
        cmp_a = cur_epoch;
        cmp_b = exp_q;
        if (cmp_eq) begin
          state_d = S_EPMAX;
        end else begin
          res_status_d = STAT_CONFLICT;
          state_d      = S_DONE;
        end
      end
      S_EPMAX: begin
        cmp_a = cur_epoch;
        cmp_b = '1;
        cnt_d = '0;
        if (cmp_eq) begin
          res_status_d = STAT_CONFLICT;
          state_d      = S_DONE;
        end else if (op_q == OP_REMOVE && !slot_loaded_q[sidx]) begin
          res_status_d = STAT_MISSING;
          state_d      = S_DONE;
        end else if (op_q == OP_PUT && kind_q == KIND_AES) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, compare the word that comes back
        rd_addr = cnt_q[ADDR_W-1:0];
        if (cnt_q < (ADDR_W + 1)'(ENTRIES)) begin
          p_vld_d = 1'b1;
          p_idx_d = cnt_q[ADDR_W-1:0];
          cnt_d   = cnt_q + 1'b1;
        end
        cmp_a = rd_data_q;
        cmp_b = key_q[p_word];
        if (p_vld_q) begin
          same_d = same_cur;
          if (p_word == KW_W'(KEY_WORDS - 1) && same_cur && slot_loaded_q[p_slot]
              && !slot_kind_q[p_slot]) begin
            res_status_d = STAT_CONFLICT;
            state_d      = S_DONE;
            p_vld_d      = 1'b0;
          end else if (p_idx_q == ADDR_W'(ENTRIES - 1)) begin
            cnt_d   = '0;
            state_d = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        if (op_q == OP_PUT) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (op_q != OP_PUT || cw == KW_W'(KEY_WORDS - 1)) begin
          upd_en       = 1'b1;
          upd_loaded   = (op_q == OP_PUT);
          upd_kind     = kind_q[0];
          res_status_d = STAT_OK;
          res_epoch_d  = epoch_inc;
          state_d      = S_DONE;
        end
      end
      S_USE: begin
        rd_addr = {sidx, cw};
        if (cnt_q < (ADDR_W + 1)'(KEY_WORDS)) begin
          p_vld_d = 1'b1;
          p_idx_d = {sidx, cw};
          cnt_d   = cnt_q + 1'b1;
        end
        if (p_vld_q) begin
          rel_we = 1'b1;
          if (p_word == KW_W'(KEY_WORDS - 1)) begin
            res_status_d = STAT_OK;
            state_d      = S_DONE;
            p_vld_d      = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      p_vld_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      slot_kind_q   <= '0;
      slot_loaded_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_epoch_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p_vld_q     <= p_vld_d;
      out_valid_q <= out_valid_d;
      if (upd_en) begin
        slot_epoch_q[sidx]  <= epoch_inc;
        slot_loaded_q[sidx] <= upd_loaded;
        if (upd_loaded) begin
          slot_kind_q[sidx] <= upd_kind;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= operation_i;
      slot_q   <= slot_i;
      kind_q   <= key_kind_i;
      key_q[0] <= key_word_0_i;
      key_q[1] <= key_word_1_i;
      key_q[2] <= key_word_2_i;
      key_q[3] <= key_word_3_i;
      exp_q    <= expected_epoch_i;
    end
    p_idx_q      <= p_idx_d;
    same_q       <= same_d;
    res_status_q <= res_status_d;
    res_epoch_q  <= res_epoch_d;
    if (rel_clr) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        rel_q[i] <= '0;
      end
    end else if (rel_we) begin
      rel_q[p_word] <= rd_data_q;
    end
    if (out_ld) begin
      status_o    <= res_status_q;
      epoch_out_o <= res_epoch_q;
      key_out_0_o <= rel_q[0];
      key_out_1_o <= rel_q[1];
      key_out_2_o <= rel_q[2];
      key_out_3_o <= rel_q[3];
    end
  end

  // key memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa] <= key_q[cw];
    end
    rd_data_q <= key_mem[rd_addr];
  end

  `VKSS_ASSERT_NEXT(a_put_loads, state_q == S_COMMIT && op_q == OP_PUT && cw == KW_W'(KEY_WORDS - 1), slot_loaded_q[sidx], "committed put did not load the slot")
  `VKSS_ASSERT(a_key_only_on_ok, (out_valid_o && status_o != STAT_OK) |-> (key_out_0_o == '0 && key_out_1_o == '0 && key_out_2_o == '0 && key_out_3_o == '0), "key released on a failed item")
  `VKSS_ASSERT(a_read_pipe_scoped, p_vld_q |-> (state_q == S_SCAN || state_q == S_USE), "memory read in flight outside scan or use")

endmodule

// ===== tb/key_slot_checker.sv =====
// checker for the versioned key slot store: predicts every reply and compares it
module key_slot_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [1:0]                          operation_i,
  input  logic [7:0]                          slot_i,
  input  logic [1:0]                          key_kind_i,
  input  vkss_pkg::word_t                     key_word_0_i,
  input  vkss_pkg::word_t                     key_word_1_i,
  input  vkss_pkg::word_t                     key_word_2_i,
  input  vkss_pkg::word_t                     key_word_3_i,
  input  vkss_pkg::word_t                     expected_epoch_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          status_i,
  input  vkss_pkg::word_t                     epoch_out_i,
  input  vkss_pkg::word_t                     key_out_0_i,
  input  vkss_pkg::word_t                     key_out_1_i,
  input  vkss_pkg::word_t                     key_out_2_i,
  input  vkss_pkg::word_t                     key_out_3_i,
  output int                                  fail_count_o,
  output int                                  open_count_o,
  output logic [vkss_pkg::SLOT_COUNT-1:0][vkss_pkg::WORD_BITS-1:0] epoch_view_o,
  output logic [vkss_pkg::SLOT_COUNT-1:0]     p256_view_o
);
  import vkss_pkg::*;

  localparam logic [255:0] GROUP_ORDER =
    {P256_ORDER[0], P256_ORDER[1], P256_ORDER[2], P256_ORDER[3]};

  typedef struct packed {
    logic [1:0]   status;
    word_t        epoch;
    logic [255:0] key;
  } slot_reply_t;

  logic [SLOT_COUNT-1:0][WORD_BITS-1:0] epoch_q, epoch_d;
  logic [SLOT_COUNT-1:0][255:0]         keys_q, keys_d;
  logic [SLOT_COUNT-1:0]                p256_q, p256_d, held_q, held_d;
  logic [255:0]                         key_in, key_got;
  logic [SLOT_W-1:0]                    idx;
  logic                                 scalar_good, twin, stale;
  logic                                 took_in, gave_out;
  slot_reply_t                          reply, due;
  slot_reply_t                          replies_due [$];

  assign took_in  = in_valid_i && in_ready_i;
  assign gave_out = out_valid_i && out_ready_i;
  assign key_in   = {key_word_0_i, key_word_1_i, key_word_2_i, key_word_3_i};
  assign key_got  = {key_out_0_i, key_out_1_i, key_out_2_i, key_out_3_i};
  assign idx      = slot_i[SLOT_W-1:0];

  task automatic flag_mismatch(input string what, input word_t got, input word_t want);
    fail_count_o++;
    $display("key slot mismatch on %s: got %h, want %h", what, got, want);
  endtask

  // reply and next table for the item on the input port right now
  always_comb begin
    epoch_d      = epoch_q;
    keys_d       = keys_q;
    p256_d       = p256_q;
    held_d       = held_q;
    reply        = '0;
    reply.status = STAT_INVALID;
    scalar_good  = (key_in != '0) && (key_in < GROUP_ORDER);
    twin         = 1'b0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (held_q[s] && !p256_q[s] && keys_q[s] == key_in) twin = 1'b1;
    end
    stale = (epoch_q[idx] != expected_epoch_i) || (epoch_q[idx] == '1);
    if (slot_i < SLOT_COUNT) begin
      case (operation_i)
        OP_PUT: begin
          if (key_kind_i > KIND_P256 || (key_kind_i == KIND_P256 && !scalar_good)) begin
            reply.status = STAT_INVALID;
          end else if (stale || (key_kind_i == KIND_AES && twin)) begin
            reply.status = STAT_CONFLICT;
          end else begin
            keys_d[idx]  = key_in;
            p256_d[idx]  = (key_kind_i == KIND_P256);
            held_d[idx]  = 1'b1;
            epoch_d[idx] = epoch_q[idx] + 1'b1;
            reply.status = STAT_OK;
            reply.epoch  = epoch_d[idx];
          end
        end
        OP_REMOVE: begin
          if (stale) begin
            reply.status = STAT_CONFLICT;
          end else if (!held_q[idx]) begin
            reply.status = STAT_MISSING;
          end else begin
            keys_d[idx]  = '0;
            held_d[idx]  = 1'b0;
            epoch_d[idx] = epoch_q[idx] + 1'b1;
            reply.status = STAT_OK;
            reply.epoch  = epoch_d[idx];
          end
        end
        OP_USE: begin
          reply.epoch = epoch_q[idx];
          if (!held_q[idx]) begin
            reply.status = STAT_MISSING;
          end else if ({1'b0, p256_q[idx]} != key_kind_i) begin
            reply.status = STAT_INVALID;
          end else begin
            reply.status = STAT_OK;
            reply.key    = keys_q[idx];
          end
        end
        default: ;
      endcase
    end
    // table as the stimulus sees it once the item on the port is taken
    epoch_view_o = took_in ? epoch_d : epoch_q;
    p256_view_o  = took_in ? p256_d : p256_q;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q      <= '0;
      keys_q       <= '0;
      p256_q       <= '0;
      held_q       <= '0;
      open_count_o <= 0;
      replies_due.delete();
    end else begin
      // the output side goes first: an item taken now cannot be answered at once
      if (gave_out) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("item with no request", word_t'(status_i), '0);
        end else begin
          due = replies_due.pop_front();
          if (status_i != due.status) begin
            flag_mismatch("status", word_t'(status_i), word_t'(due.status));
          end
          if (epoch_out_i != due.epoch) flag_mismatch("epoch_out", epoch_out_i, due.epoch);
          for (int w = 0; w < KEY_WORDS; w++) begin
            if (key_got[255-64*w -: 64] != due.key[255-64*w -: 64]) begin
              flag_mismatch($sformatf("key_out_%0d", w), key_got[255-64*w -: 64],
                            due.key[255-64*w -: 64]);
            end
          end
        end
      end
      if (took_in) begin
        replies_due.push_back(reply);
        epoch_q <= epoch_d;
        keys_q  <= keys_d;
        p256_q  <= p256_d;
        held_q  <= held_d;
      end
      open_count_o <= replies_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, stimulus and verdict for the versioned key slot store
module tb;
  import vkss_pkg::*;

  localparam logic [255:0] GROUP_ORDER =
    {P256_ORDER[0], P256_ORDER[1], P256_ORDER[2], P256_ORDER[3]};
  localparam logic [1:0]   OP_RSVD     = 2'd3;
  localparam logic [1:0]   KIND_RSVD2  = 2'd2;
  localparam logic [1:0]   KIND_RSVD3  = 2'd3;
  localparam int           RANDOM_ITEMS = 1200;

  logic         clk            = 1'b0;
  logic         rst_n          = 1'b0;
  logic         in_valid       = 1'b0;
  logic         in_ready;
  logic [1:0]   operation      = OP_PUT;
  logic [7:0]   slot           = '0;
  logic [1:0]   key_kind       = KIND_AES;
  logic [255:0] key_bits       = '0;
  word_t        expected_epoch = '0;
  logic         out_valid;
  logic         out_ready      = 1'b0;
  logic [1:0]   status;
  word_t        epoch_out, key_out_0, key_out_1, key_out_2, key_out_3;
  int           fail_count, open_count;
  bit           calm_src = 1'b0;
  logic [255:0] aes_seen [$];
  logic [SLOT_COUNT-1:0][WORD_BITS-1:0] epoch_view;
  logic [SLOT_COUNT-1:0]                p256_view;

  versioned_key_slot_store_core u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .slot_i           (slot),
    .key_kind_i       (key_kind),
    .key_word_0_i     (key_bits[255:192]),
    .key_word_1_i     (key_bits[191:128]),
    .key_word_2_i     (key_bits[127:64]),
    .key_word_3_i     (key_bits[63:0]),
    .expected_epoch_i (expected_epoch),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .epoch_out_o      (epoch_out),
    .key_out_0_o      (key_out_0),
    .key_out_1_o      (key_out_1),
    .key_out_2_o      (key_out_2),
    .key_out_3_o      (key_out_3)
  );

  key_slot_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (operation),
    .slot_i           (slot),
    .key_kind_i       (key_kind),
    .key_word_0_i     (key_bits[255:192]),
    .key_word_1_i     (key_bits[191:128]),
    .key_word_2_i     (key_bits[127:64]),
    .key_word_3_i     (key_bits[63:0]),
    .expected_epoch_i (expected_epoch),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .epoch_out_i      (epoch_out),
    .key_out_0_i      (key_out_0),
    .key_out_1_i      (key_out_1),
    .key_out_2_i      (key_out_2),
    .key_out_3_i      (key_out_3),
    .fail_count_o     (fail_count),
    .open_count_o     (open_count),
    .epoch_view_o     (epoch_view),
    .p256_view_o      (p256_view)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] rand_key();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  // mostly legal scalars, with the edges of the legal range mixed in
  function automatic logic [255:0] pick_scalar();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return GROUP_ORDER;
      2: return GROUP_ORDER - 1'b1;
      3: return 256'd1;
      4: return '1;
      5: return GROUP_ORDER + $urandom_range(1, 100);
      default: return rand_key();
    endcase
  endfunction

  // waits out the sender gap, then offers one item and holds it until taken;
  // when asked for, the epoch and kind come from the table as it stands after the last item taken
  task automatic issue(input logic [1:0] op, input logic [7:0] sl, input logic [1:0] kd,
                       input logic [255:0] key, input bit cur_epoch, input bit follow_kind,
                       input word_t ep);
    int gap;
    gap = calm_src ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    slot      <= sl;
    key_bits  <= key;
    if (follow_kind && sl < SLOT_COUNT) begin
      key_kind <= p256_view[sl[SLOT_W-1:0]] ? KIND_P256 : KIND_AES;
    end else begin
      key_kind <= kd;
    end
    expected_epoch <= (cur_epoch && sl < SLOT_COUNT) ? epoch_view[sl[SLOT_W-1:0]] : ep;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : source
    int           roll;
    logic [7:0]   sl;
    bit           right;
    word_t        ep;
    logic [255:0] key;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_USE, 8'd0, KIND_RSVD3, '0, 1'b0, 1'b0, '0);
    issue(OP_REMOVE, 8'd0, KIND_AES, '0, 1'b1, 1'b0, '0);
    issue(OP_REMOVE, 8'd0, KIND_AES, '0, 1'b0, 1'b0, 64'd5);
    issue(OP_PUT, 8'd0, KIND_AES, '1, 1'b1, 1'b0, '0);
    // same aes key again, in another slot and in its own slot
    issue(OP_PUT, 8'd1, KIND_AES, '1, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd0, KIND_AES, '1, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd1, KIND_P256, '0, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd1, KIND_P256, GROUP_ORDER, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd1, KIND_P256, GROUP_ORDER - 1'b1, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd2, KIND_P256, 256'd1, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd2, KIND_P256, '1, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd3, KIND_RSVD2, rand_key(), 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'd3, KIND_RSVD3, rand_key(), 1'b1, 1'b0, '0);
    issue(OP_USE, 8'd1, KIND_P256, '0, 1'b0, 1'b0, '0);
    issue(OP_USE, 8'd1, KIND_AES, '0, 1'b0, 1'b0, '0);
    issue(OP_USE, 8'd1, KIND_RSVD3, '0, 1'b0, 1'b0, '0);
    issue(OP_USE, 8'd0, KIND_AES, '0, 1'b0, 1'b0, '0);
    issue(OP_RSVD, 8'd0, KIND_AES, '1, 1'b1, 1'b0, '0);
    issue(OP_PUT, 8'(SLOT_COUNT), KIND_AES, rand_key(), 1'b1, 1'b0, '0);
    issue(OP_USE, 8'd255, KIND_AES, '0, 1'b0, 1'b0, '0);
    issue(OP_PUT, 8'd7, KIND_AES, '0, 1'b1, 1'b0, '0);
    issue(OP_REMOVE, 8'd0, KIND_AES, '0, 1'b1, 1'b0, '0);
    issue(OP_USE, 8'd0, KIND_AES, '0, 1'b0, 1'b0, '0);
    issue(OP_PUT, 8'd3, KIND_AES, rand_key(), 1'b0, 1'b0, '1);
    issue(OP_PUT, 8'd1, KIND_AES, rand_key(), 1'b1, 1'b0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm_src = ($urandom_range(0, 3) == 0);
      roll  = $urandom_range(0, 99);
      sl    = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(SLOT_COUNT, 255))
                                           : 8'($urandom_range(0, SLOT_COUNT - 1));
      right = ($urandom_range(0, 9) != 0);
      ep    = ($urandom_range(0, 1) == 0) ? word_t'($urandom_range(0, 40)) : rand_word();
      if (roll < 35) begin
        if (aes_seen.size() > 0 && $urandom_range(0, 6) == 0) begin
          key = aes_seen[$urandom_range(0, aes_seen.size() - 1)];
        end else begin
          key = rand_key();
          aes_seen.push_back(key);
          if (aes_seen.size() > 32) aes_seen.delete(0);
        end
        issue(OP_PUT, sl, KIND_AES, key, right, 1'b0, ep);
      end else if (roll < 55) begin
        issue(OP_PUT, sl, KIND_P256, pick_scalar(), right, 1'b0, ep);
      end else if (roll < 70) begin
        issue(OP_REMOVE, sl, KIND_AES, rand_key(), right, 1'b0, ep);
      end else if (roll < 88) begin
        issue(OP_USE, sl, 2'($urandom_range(0, 3)), rand_key(), 1'b0,
              $urandom_range(0, 6) != 0, ep);
      end else begin
        // noise over the whole range of every field
        issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              2'($urandom_range(0, 3)), rand_key(), 1'b0, 1'b0, rand_word());
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (open_count != 0);
    repeat (60) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : sink
    int hold;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (taken % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      hold = calm ? 0 : $urandom_range(0, 7);
      // long hold-offs so the block backs up and stalls its input
      if (taken == 150 || taken == 700) hold = 400;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
